[hdl/gtpv_pkg.sv]
package gtpv_pkg;

    localparam int TABLE_LEN = 24;
    localparam int FRAC_BITS = 14;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    // atan(2^-i) in 32-bit binary angle units
    localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
        32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81
    };

endpackage

[hdl/gtpv_cordic_stage.sv]
// One CORDIC micro-rotation with a register behind it.
// Vectoring drives y toward zero; rotation drives z toward zero.
module gtpv_cordic_stage #(
    parameter int STEP = 0,
    parameter int VW   = 40,
    parameter bit VECTORING = 1'b1,
    parameter int SW   = 21
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [VW-1:0] i_x,
    input  logic signed [VW-1:0] i_y,
    input  logic        [31:0]   i_z,
    input  logic        [SW-1:0] i_side,
    output logic                 o_valid,
    output logic signed [VW-1:0] o_x,
    output logic signed [VW-1:0] o_y,
    output logic        [31:0]   o_z,
    output logic        [SW-1:0] o_side
);
    import gtpv_pkg::*;

    logic                 pos;
    logic signed [VW-1:0] sx, sy;

    // pick rotation sense and arithmetic-shift both legs
    always_comb begin
        pos = VECTORING ? !i_y[VW-1] : !i_z[31];
        sx  = i_x >>> STEP;
        sy  = i_y >>> STEP;
    end

    // advance valid every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    // hold the rotated vector and angle
    always_ff @(posedge i_clk) begin
        o_side <= i_side;
        if (VECTORING) begin
            o_x <= pos ? i_x + sy : i_x - sy;
            o_y <= pos ? i_y - sx : i_y + sx;
            o_z <= pos ? i_z + ATAN_TAB[STEP] : i_z - ATAN_TAB[STEP];
        end else begin
            o_x <= pos ? i_x - sy : i_x + sy;
            o_y <= pos ? i_y + sx : i_y - sx;
            o_z <= pos ? i_z - ATAN_TAB[STEP] : i_z + ATAN_TAB[STEP];
        end
    end

endmodule

[hdl/go_to_point_velocity.sv]
// Holonomic go-to-point velocity. A pose word is taken on any rising edge with
// start high (busy is always low) and its command appears on o_valid for
// exactly one cycle (CORDIC steps capped at 24); one word per cycle is
// sustained. Each word passes through the input register, the two chains of
// CORDIC stages (bearing vectoring, then velocity rotation) with one register
// per micro-rotation, the relative-angle register between them and the output
// register. The receiver cannot stall the output; every word yields exactly
// one command.
module go_to_point_velocity #(
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_target_x,
    input  logic signed [15:0] i_target_y,
    input  logic signed [15:0] i_robot_x,
    input  logic signed [15:0] i_robot_y,
    input  logic signed [15:0] i_robot_heading,
    input  logic        [14:0] i_linear_speed,
    input  logic signed [15:0] i_angular_speed,
    input  logic               i_team_yellow,
    input  logic        [3:0]  i_robot_id,
    output logic               o_valid,
    output logic               o_team_flag_out,
    output logic        [3:0]  o_robot_id_out,
    output logic signed [15:0] o_vel_x,
    output logic signed [15:0] o_vel_y,
    output logic signed [15:0] o_vel_turn
);
    import gtpv_pkg::*;

    localparam int NS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam logic [31:0] AMASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
    // vector width: 17-bit offset << 14, plus CORDIC growth
    localparam int VW = 34;
    // side data: heading 16, speed 15, ang 16, team 1, id 4, zero 1
    localparam int SW = 53;

    assign busy = 1'b0;

    // ---- stage 0: offsets, half-plane fold ----
    logic signed [16:0] dx, dy;
    logic               r_v0;
    logic signed [VW-1:0] r_x0, r_y0;
    logic [31:0]          r_z0;
    logic [SW-1:0]        r_s0;

    always_comb begin
        dx = 17'(i_target_x) - 17'(i_robot_x);
        dy = 17'(i_target_y) - 17'(i_robot_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start;
        end
    end

    // fold left half-plane into right, start angle at pi
    always_ff @(posedge i_clk) begin
        if (dx[16]) begin
            r_x0 <= -(VW'(dx) <<< FRAC_BITS);
            r_y0 <= -(VW'(dy) <<< FRAC_BITS);
            r_z0 <= HALF_TURN;
        end else begin
            r_x0 <= VW'(dx) <<< FRAC_BITS;
            r_y0 <= VW'(dy) <<< FRAC_BITS;
            r_z0 <= '0;
        end
        r_s0 <= {i_robot_heading, i_linear_speed, i_angular_speed, i_team_yellow,
                 i_robot_id, (dx == 17'sd0) && (dy == 17'sd0)};
    end

    // ---- bearing chain ----
    logic               bv [NS+1];
    logic signed [VW-1:0] bx [NS+1], by [NS+1];
    logic [31:0]          bz [NS+1];
    logic [SW-1:0]        bs [NS+1];

    assign bv[0] = r_v0;
    assign bx[0] = r_x0;
    assign by[0] = r_y0;
    assign bz[0] = r_z0;
    assign bs[0] = r_s0;

    for (genvar g = 0; g < NS; g++) begin : g_vec
        gtpv_cordic_stage #(.STEP(g), .VW(VW), .VECTORING(1'b1), .SW(SW)) u_stage (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_valid(bv[g]), .i_x(bx[g]), .i_y(by[g]), .i_z(bz[g]), .i_side(bs[g]),
            .o_valid(bv[g+1]), .o_x(bx[g+1]), .o_y(by[g+1]), .o_z(bz[g+1]),
            .o_side(bs[g+1])
        );
    end

    // ---- stage R: relative angle, quadrant fold, gain multiply ----
    logic [31:0] bear, rel, head;
    logic [14:0] spd;
    logic [44:0] prod;
    logic        r_v1, r_mv1, r_left1;
    logic [31:0] r_z1;
    logic signed [VW-1:0] r_x1;
    logic [SW-1:0] r_s1;

    always_comb begin
        head = {bs[NS][52:37], 16'd0};
        spd  = bs[NS][36:22];
        bear = bs[NS][0] ? 32'd0 : bz[NS];
        rel  = ((bear & AMASK) - (head & AMASK)) & AMASK;
        prod = 45'(spd) * 45'(GAIN_Q30);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= bv[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_mv1   <= (rel[31:30] == 2'b01) || (rel[31:30] == 2'b10);
        r_z1    <= ((rel[31:30] == 2'b01) || (rel[31:30] == 2'b10)) ? rel + HALF_TURN : rel;
        r_left1 <= (rel != 32'd0) && (rel <= HALF_TURN);
        r_x1    <= VW'(prod[44:16]);
        r_s1    <= bs[NS];
    end

    // ---- rotation chain; move flag and turn sense ride in side bits ----
    localparam int RW = SW + 2;
    logic               rv [NS+1];
    logic signed [VW-1:0] rx [NS+1], ry [NS+1];
    logic [31:0]          rz [NS+1];
    logic [RW-1:0]        rs [NS+1];

    assign rv[0] = r_v1;
    assign rx[0] = r_x1;
    assign ry[0] = '0;
    assign rz[0] = r_z1;
    assign rs[0] = {r_mv1, r_left1, r_s1};

    for (genvar g = 0; g < NS; g++) begin : g_rot
        gtpv_cordic_stage #(.STEP(g), .VW(VW), .VECTORING(1'b0), .SW(RW)) u_stage (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_valid(rv[g]), .i_x(rx[g]), .i_y(ry[g]), .i_z(rz[g]), .i_side(rs[g]),
            .o_valid(rv[g+1]), .o_x(rx[g+1]), .o_y(ry[g+1]), .o_z(rz[g+1]),
            .o_side(rs[g+1])
        );
    end

    // ---- output: round, unfold, saturate ----
    logic signed [VW-1:0] qx, qy, fx, fy;
    logic signed [16:0]   ang, nt;
    logic                 mv, left;

    function automatic logic signed [15:0] sat_v(input logic signed [VW-1:0] v);
        if (v > 34'sd32767) begin
            return 16'sd32767;
        end else if (v < -34'sd32767) begin
            return -16'sd32767;
        end else begin
            return v[15:0];
        end
    endfunction

    always_comb begin
        mv   = rs[NS][RW-1];
        left = rs[NS][RW-2];
        qx   = (rx[NS] + VW'(8192)) >>> FRAC_BITS;
        qy   = (ry[NS] + VW'(8192)) >>> FRAC_BITS;
        fx   = mv ? -qx : qx;
        fy   = mv ? -qy : qy;
        ang  = 17'(signed'(rs[NS][21:6]));
        nt   = -ang;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= rv[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        o_team_flag_out <= rs[NS][5];
        o_robot_id_out  <= rs[NS][4:1];
        o_vel_x         <= sat_v(fx);
        o_vel_y         <= sat_v(fy);
        if (left) begin
            o_vel_turn <= ang[15:0];
        end else if (nt > 17'sd32767) begin
            o_vel_turn <= 16'sd32767;
        end else begin
            o_vel_turn <= nt[15:0];
        end
    end

    // velocities never reach the most negative code
    a_vx_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_vel_x != 16'sh8000)) else $error("vel_x out of range");
    a_vy_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_vel_y != 16'sh8000)) else $error("vel_y out of range");
    a_busy: assert property (@(posedge i_clk) !busy) else $error("busy raised");
    a_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |=> rv[1]) else $error("rotation stage lost a word");

endmodule

[tb/gtpv_checker.sv]
`timescale 1ns / 100ps

module gtpv_checker #(
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] i_target_x,
    input  logic signed [15:0] i_target_y,
    input  logic signed [15:0] i_robot_x,
    input  logic signed [15:0] i_robot_y,
    input  logic signed [15:0] i_robot_heading,
    input  logic        [14:0] i_linear_speed,
    input  logic signed [15:0] i_angular_speed,
    input  logic               i_team_yellow,
    input  logic        [3:0]  i_robot_id,
    input  logic               o_valid,
    input  logic               o_team_flag_out,
    input  logic        [3:0]  o_robot_id_out,
    input  logic signed [15:0] o_vel_x,
    input  logic signed [15:0] o_vel_y,
    input  logic signed [15:0] o_vel_turn,
    output int                 fail_count,
    output int                 pending_cmds
);
    import gtpv_pkg::*;

    typedef struct packed {
        logic               team;
        logic        [3:0]  id;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vturn;
    } t_cmd;

    t_cmd cmd_q[$];

    assign pending_cmds = cmd_q.size();

    function automatic int num_steps();
        return (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    endfunction

    // Shift right with rounding toward minus infinity
    function automatic longint fshr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic logic [31:0] target_bearing(longint dx, longint dy);
        longint x, y, nx;
        logic [31:0] z;
        z = '0;
        if (dx == 0 && dy == 0)
            return '0;
        x = dx <<< FRAC_BITS;
        y = dy <<< FRAC_BITS;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < num_steps(); i++) begin
            if (y >= 0) begin
                nx = x + fshr(y, i);
                y  = y - fshr(x, i);
                z  = z + ATAN_TAB[i];
            end else begin
                nx = x - fshr(y, i);
                y  = y + fshr(x, i);
                z  = z - ATAN_TAB[i];
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint clamp16(longint v, longint lo);
        if (v > 32767)
            return 32767;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic t_cmd predict_cmd(
        logic signed [15:0] tx, logic signed [15:0] ty,
        logic signed [15:0] rx, logic signed [15:0] ry,
        logic [15:0] head, logic [14:0] spd, logic signed [15:0] ang,
        logic team, logic [3:0] id
    );
        t_cmd c;
        logic [31:0] mask, rel, z;
        logic moved;
        longint x, y, nx;
        mask = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
        rel = (target_bearing(longint'(tx) - longint'(rx), longint'(ty) - longint'(ry))
               & mask) - ({head, 16'h0} & mask);
        rel = rel & mask;
        moved = (rel[31:30] == 2'b01) || (rel[31:30] == 2'b10);
        z = moved ? rel + HALF_TURN : rel;
        x = fshr(longint'(spd) * longint'(GAIN_Q30), 16);
        y = 0;
        for (int i = 0; i < num_steps(); i++) begin
            if (!z[31]) begin
                nx = x - fshr(y, i);
                y  = y + fshr(x, i);
                z  = z - ATAN_TAB[i];
            end else begin
                nx = x + fshr(y, i);
                y  = y - fshr(x, i);
                z  = z + ATAN_TAB[i];
            end
            x = nx;
        end
        x = fshr(x + (64'sd1 <<< (FRAC_BITS - 1)), FRAC_BITS);
        y = fshr(y + (64'sd1 <<< (FRAC_BITS - 1)), FRAC_BITS);
        if (moved) begin
            x = -x;
            y = -y;
        end
        c.team = team;
        c.id = id;
        c.vx = 16'(clamp16(x, -32767));
        c.vy = 16'(clamp16(y, -32767));
        // Left turn for rel in (0, pi], right otherwise
        if (rel != 0 && rel <= HALF_TURN)
            c.vturn = ang;
        else
            c.vturn = 16'(clamp16(-longint'(ang), -32768));
        return c;
    endfunction

    // Predict on each accepted word, compare each command
    always @(posedge i_clk) begin
        t_cmd e;
        if (!i_rst_n) begin
            fail_count <= 0;
        end else begin
            if (o_valid) begin
                if (cmd_q.size() == 0) begin
                    $display("%0t: unexpected command id=%0d vx=%0d vy=%0d vt=%0d",
                             $time, o_robot_id_out, o_vel_x, o_vel_y, o_vel_turn);
                    fail_count <= fail_count + 1;
                end else begin
                    e = cmd_q.pop_front();
                    if (e.team !== o_team_flag_out || e.id !== o_robot_id_out ||
                        e.vx !== o_vel_x || e.vy !== o_vel_y ||
                        e.vturn !== o_vel_turn) begin
                        $display("%0t: mismatch exp team=%0d id=%0d vx=%0d vy=%0d vt=%0d",
                                 $time, e.team, e.id, e.vx, e.vy, e.vturn);
                        $display("%0t:          got team=%0d id=%0d vx=%0d vy=%0d vt=%0d",
                                 $time, o_team_flag_out, o_robot_id_out, o_vel_x,
                                 o_vel_y, o_vel_turn);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                cmd_q.push_back(predict_cmd(i_target_x, i_target_y, i_robot_x, i_robot_y,
                                            i_robot_heading, i_linear_speed,
                                            i_angular_speed, i_team_yellow, i_robot_id));
        end
    end
endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    localparam int N_RANDOM = 1200;
    localparam int DRAIN = 2 * 16 + 4 + 20;
    localparam int LIMIT = 200000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] i_target_x, i_target_y, i_robot_x, i_robot_y;
    logic signed [15:0] i_robot_heading, i_angular_speed;
    logic        [14:0] i_linear_speed;
    logic               i_team_yellow;
    logic        [3:0]  i_robot_id;
    logic               o_valid, o_team_flag_out;
    logic        [3:0]  o_robot_id_out;
    logic signed [15:0] o_vel_x, o_vel_y, o_vel_turn;
    int                 fail_count, pending_cmds;
    int                 cycles;

    go_to_point_velocity DUT (.*);
    gtpv_checker checker_i (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stop a hung run
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Present one word and hold it until accepted
    task automatic send_word(logic signed [15:0] tx, logic signed [15:0] ty,
                             logic signed [15:0] rx, logic signed [15:0] ry,
                             logic signed [15:0] hd, logic [14:0] spd,
                             logic signed [15:0] ang);
        start <= 1'b1;
        i_target_x <= tx;
        i_target_y <= ty;
        i_robot_x <= rx;
        i_robot_y <= ry;
        i_robot_heading <= hd;
        i_linear_speed <= spd;
        i_angular_speed <= ang;
        i_team_yellow <= 1'($urandom);
        i_robot_id <= 4'($urandom);
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rnd_coord();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 200)) - 16'd100;
            1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic signed [15:0] rx, ry, hd;
        start = 1'b0;
        i_rst_n = 1'b0;
        {i_target_x, i_target_y, i_robot_x, i_robot_y} = '0;
        {i_robot_heading, i_angular_speed, i_linear_speed} = '0;
        i_team_yellow = 1'b0;
        i_robot_id = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero offset, axes, corners, turn edges, speed extremes
        send_word(0, 0, 0, 0, 0, 15'h7FFF, 16'sh8000);
        send_word(100, 100, 100, 100, 16'sh4000, 1000, 500);
        send_word(1000, 0, 0, 0, 0, 15'h7FFF, 16'sh8000);
        send_word(-1000, 0, 0, 0, 0, 15'h7FFF, 16'sh7FFF);
        send_word(0, 1000, 0, 0, 0, 15'h7FFF, -1);
        send_word(0, -1000, 0, 0, 0, 15'h7FFF, 16'sh8000);
        send_word(-1000, 0, 0, 0, 16'sh8000, 0, 1);
        send_word(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 0, 15'h7FFF, 7);
        send_word(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 15'h7FFF, 7);
        send_word(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 1, 16'sh8000);
        send_word(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'shC000, 15'h7FFF, 0);
        send_word(1, 0, 0, 0, 16'sh7FFF, 15'h7FFF, 16'sh7FFF);
        send_word(0, 0, 0, 0, 16'sh8000, 15'h7FFF, 16'sh8000);
        send_word(-1, -1, 0, 0, 16'sh2000, 15'h5555, 16'sh5555);

        // Hold off until every command is back
        start <= 1'b0;
        while (pending_cmds != 0) @(posedge i_clk);

        // Random words, bursty gaps in the first part only
        for (int n = 0; n < N_RANDOM; n++) begin
            rx = rnd_coord();
            ry = rnd_coord();
            hd = $urandom_range(0, 7) == 0 ? 16'(($urandom_range(0, 3)) << 14) : 16'($urandom);
            if ($urandom_range(0, 15) == 0)
                send_word(rx, ry, rx, ry, hd, 15'($urandom), 16'($urandom));
            else
                send_word(rnd_coord(), rnd_coord(), rx, ry, hd,
                          $urandom_range(0, 7) == 0 ? 15'h7FFF : 15'($urandom),
                          $urandom_range(0, 7) == 0 ? 16'sh8000 : 16'($urandom));
            if (n < N_RANDOM - 200 && $urandom_range(0, 5) == 0)
                idle_cycles($urandom_range(1, 14));
        end
        start <= 1'b0;

        while (pending_cmds != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
